// ----- src/mpm_pkg.sv -----
// shared types and constants for the mecanum percent mixer
package mpm_pkg;

  // field widths
  localparam int PCT_W   = 8;               // signed percent in and out
  localparam int MAG_W   = 7;               // magnitude register
  localparam int WHEELS  = 4;
  localparam int WHEEL_W = 10;              // signed mixed wheel, up to +/-300
  localparam int ABS_W   = 9;               // wheel magnitude, up to 300
  localparam int PROD_W  = ABS_W + MAG_W;   // magnitude times limit
  localparam int NUM_W   = 16;              // rounding numerator, up to 60300
  localparam int DEN_W   = ABS_W + 1;       // twice the largest magnitude
  localparam int QUOT_W  = 7;               // quotient never exceeds the limit

  // magnitude limits
  localparam logic [MAG_W-1:0] MAG_LIMIT = 7'd100;
  localparam logic [MAG_W-1:0] MAG_RESET = 7'd100;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_MAX_MAG = 1'b0;      // register index bit of paddr

  // wheel order
  localparam int FL = 0;
  localparam int FR = 1;
  localparam int RL = 2;
  localparam int RR = 3;

  // input beat
  typedef struct packed {
    logic signed [PCT_W-1:0] forward_pct;
    logic signed [PCT_W-1:0] left_pct;
    logic signed [PCT_W-1:0] turn_pct;
  } mpm_in_t;

  // result beat
  typedef struct packed {
    logic signed [PCT_W-1:0] front_left_cmd;
    logic signed [PCT_W-1:0] front_right_cmd;
    logic signed [PCT_W-1:0] rear_left_cmd;
    logic signed [PCT_W-1:0] rear_right_cmd;
  } mpm_out_t;

  // side data carried alongside the divider
  typedef struct packed {
    logic                             scale;
    logic [WHEELS-1:0][WHEEL_W-1:0]   wheel;
  } mpm_tag_t;

endpackage

// ----- src/mpm_div.sv -----
// four-lane pipelined restoring divider, one quotient bit per stage
module mpm_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic [mpm_pkg::WHEELS-1:0][mpm_pkg::NUM_W-1:0] num_i,
  input  logic [mpm_pkg::DEN_W-1:0]                 den_i,
  input  mpm_pkg::mpm_tag_t                         tag_i,
  output logic                                      valid_o,
  output logic [mpm_pkg::WHEELS-1:0][mpm_pkg::QUOT_W-1:0] quot_o,
  output mpm_pkg::mpm_tag_t                         tag_o
);
  import mpm_pkg::*;

  // stage registers
  logic                             vld_q  [QUOT_W];
  logic [DEN_W-1:0]                 den_q  [QUOT_W];
  mpm_tag_t                         tag_q  [QUOT_W];
  logic [WHEELS-1:0][NUM_W-1:0]     rem_q  [QUOT_W];
  logic [WHEELS-1:0][QUOT_W-1:0]    quot_q [QUOT_W];

  genvar s;
  for (s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int Bit = QUOT_W - 1 - s;

    logic                           vld_in;
    logic [DEN_W-1:0]               den_in;
    mpm_tag_t                       tag_in;
    logic [WHEELS-1:0][NUM_W-1:0]   rem_in;
    logic [WHEELS-1:0][QUOT_W-1:0]  quot_in;
    logic [WHEELS-1:0][NUM_W-1:0]   rem_d;
    logic [WHEELS-1:0][QUOT_W-1:0]  quot_d;
    logic [NUM_W:0]                 dsh;

    // stage input: ports for the first, previous stage otherwise
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign tag_in  = tag_i;
      assign rem_in  = num_i;
      assign quot_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign den_in  = den_q[s-1];
      assign tag_in  = tag_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    // trial subtract of the shifted divisor in every lane
    always_comb begin
      dsh    = (NUM_W+1)'(den_in) << Bit;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int l = 0; l < WHEELS; l++) begin
        if ({1'b0, rem_in[l]} >= dsh) begin
          rem_d[l]       = rem_in[l] - dsh[NUM_W-1:0];
          quot_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s]  <= den_in;
      tag_q[s]  <= tag_in;
      rem_q[s]  <= rem_d;
      quot_q[s] <= quot_d;
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign quot_o  = quot_q[QUOT_W-1];
  assign tag_o   = tag_q[QUOT_W-1];

endmodule

// ----- src/mecanum_percent_mixer.sv -----
// top level of the mecanum percent mixer
// Mecanum wheel mixer on percent commands.
// A command beat (forward, left, turn percent) is taken at a rising edge with
// start high; busy is always low, so a beat may be given in every cycle.
// Each command is clamped to +/-M, mixed into four wheels, and if the largest
// wheel magnitude exceeds M every wheel is rescaled to round(w*M/max), half
// away from zero, then clamped to +/-M again. M is max_magnitude, capped at 100.
// A result beat shows on result_o with done_o high for one cycle, once its
// command beat has passed all register stages. Throughput is one beat per
// cycle, set by the twelve register stages of the datapath: clamp, mix, max
// and multiply, numerator, seven divider stages (one quotient bit each) and
// the output register.
// Results come out in command order; the receiver cannot stall them.
// max_magnitude sits at byte address 0 of the APB port. The user must write
// it only while no command is in flight; the block itself does not enforce
// this. Reset sets it to 100 and empties the pipeline.
module mecanum_percent_mixer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  mpm_pkg::mpm_in_t             cmd_i,
  output logic                         done_o,
  output mpm_pkg::mpm_out_t            result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpm_pkg::APB_AW-1:0]   paddr,
  input  logic [mpm_pkg::APB_DW-1:0]   pwdata,
  output logic [mpm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import mpm_pkg::*;

  // saturate a signed value to +/-m
  function automatic logic signed [WHEEL_W-1:0] clamp_mag(logic signed [WHEEL_W-1:0] v,
                                                          logic [MAG_W-1:0] m);
    logic signed [WHEEL_W-1:0] ms;
    logic signed [WHEEL_W-1:0] nms;
    ms  = $signed({{(WHEEL_W-MAG_W){1'b0}}, m});
    nms = -ms;
    if (v > ms) begin
      return ms;
    end else if (v < nms) begin
      return nms;
    end
    return v;
  endfunction

  // configuration register
  logic [MAG_W-1:0] max_mag_q;
  logic [MAG_W-1:0] mag_eff;
  logic             cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_MAX_MAG) ? APB_DW'(max_mag_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mag_q <= MAG_RESET;
    end else if (cfg_wr && paddr[APB_AW-1] == REG_MAX_MAG) begin
      max_mag_q <= pwdata[MAG_W-1:0];
    end
  end

  assign mag_eff = (max_mag_q > MAG_LIMIT) ? MAG_LIMIT : max_mag_q;
  assign busy    = 1'b0;

  // stage 1: clamp the three commands
  logic                      s1_vld_q;
  logic signed [PCT_W-1:0]   x_q, y_q, r_q;
  logic signed [WHEEL_W-1:0] x_c, y_c, r_c;

  always_comb begin
    x_c = clamp_mag(WHEEL_W'(cmd_i.forward_pct), mag_eff);
    y_c = clamp_mag(WHEEL_W'(cmd_i.left_pct), mag_eff);
    r_c = clamp_mag(WHEEL_W'(cmd_i.turn_pct), mag_eff);
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_c[PCT_W-1:0];
    y_q <= y_c[PCT_W-1:0];
    r_q <= r_c[PCT_W-1:0];
  end

  // stage 2: mix into wheels and take magnitudes
  logic                            s2_vld_q;
  logic [WHEELS-1:0][WHEEL_W-1:0]  w2_d, w2_q;
  logic [WHEELS-1:0][ABS_W-1:0]    a2_d, a2_q;
  logic signed [WHEEL_W-1:0]       xe, ye, re, wt, wa;

  always_comb begin
    xe = WHEEL_W'(x_q);
    ye = WHEEL_W'(y_q);
    re = WHEEL_W'(r_q);
    w2_d[FL] = xe + ye + re;
    w2_d[FR] = xe - ye - re;
    w2_d[RL] = xe - ye + re;
    w2_d[RR] = xe + ye - re;
    for (int l = 0; l < WHEELS; l++) begin
      wt      = $signed(w2_d[l]);
      wa      = (wt < 0) ? -wt : wt;
      a2_d[l] = wa[ABS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    w2_q <= w2_d;
    a2_q <= a2_d;
  end

  // stage 3: largest magnitude and magnitude times limit
  logic                            s3_vld_q;
  logic [ABS_W-1:0]                mx_lo, mx_hi, mx_d, mx_q;
  logic [WHEELS-1:0][PROD_W-1:0]   prod_d, prod_q;
  logic [WHEELS-1:0][WHEEL_W-1:0]  w3_q;

  always_comb begin
    mx_lo = (a2_q[FL] > a2_q[FR]) ? a2_q[FL] : a2_q[FR];
    mx_hi = (a2_q[RL] > a2_q[RR]) ? a2_q[RL] : a2_q[RR];
    mx_d  = (mx_lo > mx_hi) ? mx_lo : mx_hi;
    for (int l = 0; l < WHEELS; l++) begin
      prod_d[l] = PROD_W'(a2_q[l]) * PROD_W'(mag_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    prod_q <= prod_d;
    w3_q   <= w2_q;
  end

  // stage 4: rounding numerator, divisor and scale decision
  logic                            s4_vld_q;
  logic [WHEELS-1:0][NUM_W-1:0]    num_d, num_q;
  logic [DEN_W-1:0]                den_q;
  mpm_tag_t                        tag4_q;

  always_comb begin
    for (int l = 0; l < WHEELS; l++) begin
      num_d[l] = NUM_W'({prod_q[l], 1'b0}) + NUM_W'(mx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    den_q        <= {mx_q, 1'b0};
    tag4_q.scale <= (mx_q > ABS_W'(mag_eff));
    tag4_q.wheel <= w3_q;
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start & ~busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // divider stages
  logic                            dv_vld;
  logic [WHEELS-1:0][QUOT_W-1:0]   dv_quot;
  mpm_tag_t                        dv_tag;

  mpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .tag_i   (tag4_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .tag_o   (dv_tag)
  );

  // output stage: apply sign, pick scaled or plain wheel, clamp
  logic [WHEELS-1:0][PCT_W-1:0]    cmd_d;
  logic signed [WHEEL_W-1:0]       wv, qv, ov;

  always_comb begin
    for (int l = 0; l < WHEELS; l++) begin
      wv = $signed(dv_tag.wheel[l]);
      qv = $signed(WHEEL_W'(dv_quot[l]));
      if (dv_tag.scale) begin
        ov = (wv < 0) ? -qv : qv;
      end else begin
        ov = wv;
      end
      ov       = clamp_mag(ov, mag_eff);
      cmd_d[l] = ov[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.front_left_cmd  <= cmd_d[FL];
    result_o.front_right_cmd <= cmd_d[FR];
    result_o.rear_left_cmd   <= cmd_d[RL];
    result_o.rear_right_cmd  <= cmd_d[RR];
  end

endmodule
